>>> rtl/assert_macros.svh
// Assertion macros shared by checker modules.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every rising clock edge outside reset.
`define PVS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("pvs check failed");
// Implication checked on every rising clock edge outside reset.
`define PVS_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error("pvs check failed");
`endif

>>> rtl/pvs_pkg.sv
// Shared types, constants and the arctangent table for polar_vector_sum.
// No dependencies.
`default_nettype none
package pvs_pkg;
  localparam int LW  = 16;
  localparam int AW  = 17;
  localparam int OLW = 17;
  localparam int OAW = 16;
  localparam int RW  = 34;
  localparam int VW  = 36;
  localparam int ZW  = 32;

  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int FULL_TURN    = 46080;
  localparam logic signed [ZW-1:0] DEG180 = 32'sd188743680;
  localparam logic [28:0] GAIN_SQ_INV = 29'd395948877;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } rot_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 32'sd47185920;
      1:  r = 32'sd27855475;
      2:  r = 32'sd14718068;
      3:  r = 32'sd7471121;
      4:  r = 32'sd3750058;
      5:  r = 32'sd1876857;
      6:  r = 32'sd938658;
      7:  r = 32'sd469357;
      8:  r = 32'sd234682;
      9:  r = 32'sd117342;
      10: r = 32'sd58671;
      11: r = 32'sd29335;
      12: r = 32'sd14668;
      13: r = 32'sd7334;
      14: r = 32'sd3667;
      15: r = 32'sd1833;
      16: r = 32'sd917;
      17: r = 32'sd458;
      18: r = 32'sd229;
      19: r = 32'sd115;
      20: r = 32'sd57;
      21: r = 32'sd29;
      22: r = 32'sd14;
      23: r = 32'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/polar_vector_sum.sv
// Path: input register, rotation cells, sum register, vectoring cells, gain registers.
// Throughput: one vector pair per cycle; the whole pipeline holds when the
// result is stalled, and each rotation/vectoring cell holds one micro-rotation.
// Reset: rst clears only the stage valid bits; data registers are not reset.
// Depends on pvs_pkg, pvs_rot_cell, pvs_vec_cell, pvs_gain.
`default_nettype none
module polar_vector_sum #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [pvs_pkg::LW-1:0]         first_length,
  input  logic signed [pvs_pkg::AW-1:0]  first_angle,
  input  logic [pvs_pkg::LW-1:0]         second_length,
  input  logic signed [pvs_pkg::AW-1:0]  second_angle,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [pvs_pkg::OLW-1:0]        sum_length,
  output logic signed [pvs_pkg::OAW-1:0] sum_angle
);
  import pvs_pkg::*;

  localparam int STAGES = 2 * CORDIC_STEPS + 4;

  logic [STAGES-1:0] vld;
  logic en;
  rot_t r1 [0:CORDIC_STEPS];
  rot_t r2 [0:CORDIC_STEPS];
  vec_t v [0:CORDIC_STEPS];
  logic signed [VW-1:0] sum_x;
  logic signed [VW-1:0] sum_y;

  function automatic rot_t prep(input logic [LW-1:0] len, input logic signed [AW-1:0] ang);
    logic signed [AW:0] a;
    rot_t r;
    a = (AW+1)'(ang);
    if (a >= HALF_TURN) begin
      a = a - (AW+1)'(FULL_TURN);
    end else if (a < -HALF_TURN) begin
      a = a + (AW+1)'(FULL_TURN);
    end
    r.flip = 1'b0;
    if (a > QUARTER_TURN) begin
      a = a - (AW+1)'(HALF_TURN);
      r.flip = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a = a + (AW+1)'(HALF_TURN);
      r.flip = 1'b1;
    end
    r.x = RW'({len, 14'b0});
    r.y = '0;
    r.z = ZW'(a) <<< 13;
    return r;
  endfunction

  function automatic logic signed [VW-1:0] comp(input logic signed [RW-1:0] c, input logic f);
    logic signed [VW-1:0] e;
    e = VW'(c);
    return f ? -e : e;
  endfunction

  assign en = !vld[STAGES-1] || !rsp_stall;
  assign req_stall = !en;
  assign rsp_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1[0] <= prep(first_length, first_angle);
      r2[0] <= prep(second_length, second_angle);
      sum_x <= comp(r1[CORDIC_STEPS].x, r1[CORDIC_STEPS].flip)
             + comp(r2[CORDIC_STEPS].x, r2[CORDIC_STEPS].flip);
      sum_y <= comp(r1[CORDIC_STEPS].y, r1[CORDIC_STEPS].flip)
             + comp(r2[CORDIC_STEPS].y, r2[CORDIC_STEPS].flip);
    end
  end

  always_comb begin
    v[0].zero = (sum_x == '0) && (sum_y == '0);
    if (sum_x[VW-1]) begin
      v[0].x = -sum_x;
      v[0].y = -sum_y;
      v[0].z = sum_y[VW-1] ? -DEG180 : DEG180;
    end else begin
      v[0].x = sum_x;
      v[0].y = sum_y;
      v[0].z = '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cells
    pvs_rot_cell #(.STEP(i)) u_rot1 (.clk(clk), .en(en), .d(r1[i]), .q(r1[i+1]));
    pvs_rot_cell #(.STEP(i)) u_rot2 (.clk(clk), .en(en), .d(r2[i]), .q(r2[i+1]));
    pvs_vec_cell #(.STEP(i)) u_vec (.clk(clk), .en(en), .d(v[i]), .q(v[i+1]));
  end

  pvs_gain u_gain (
    .clk(clk),
    .en(en),
    .d(v[CORDIC_STEPS]),
    .sum_length(sum_length),
    .sum_angle(sum_angle)
  );
endmodule
`default_nettype wire

>>> rtl/pvs_rot_cell.sv
// One rotation-mode CORDIC micro-rotation with its output register.
// Depends on pvs_pkg.
`default_nettype none
module pvs_rot_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  pvs_pkg::rot_t d,
  output pvs_pkg::rot_t q
);
  import pvs_pkg::*;

  rot_t q_next;
  logic signed [RW-1:0] dx;
  logic signed [RW-1:0] dy;

  always_comb begin
    dx = d.y >>> STEP;
    dy = d.x >>> STEP;
    q_next = d;
    if (!d.z[ZW-1]) begin
      q_next.x = d.x - dx;
      q_next.y = d.y + dy;
      q_next.z = d.z - atan_tab(STEP);
    end else begin
      q_next.x = d.x + dx;
      q_next.y = d.y - dy;
      q_next.z = d.z + atan_tab(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end
endmodule
`default_nettype wire

>>> rtl/pvs_vec_cell.sv
// One vectoring-mode CORDIC micro-rotation with its output register.
// Depends on pvs_pkg.
`default_nettype none
module pvs_vec_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  pvs_pkg::vec_t d,
  output pvs_pkg::vec_t q
);
  import pvs_pkg::*;

  vec_t q_next;
  logic signed [VW-1:0] dx;
  logic signed [VW-1:0] dy;

  always_comb begin
    dx = d.y >>> STEP;
    dy = d.x >>> STEP;
    q_next = d;
    if (d.y[VW-1]) begin
      q_next.x = d.x - dx;
      q_next.y = d.y + dy;
      q_next.z = d.z - atan_tab(STEP);
    end else begin
      q_next.x = d.x + dx;
      q_next.y = d.y - dy;
      q_next.z = d.z + atan_tab(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end
endmodule
`default_nettype wire

>>> rtl/pvs_gain.sv
// Gain removal, length rounding and angle rounding; two register stages.
// Depends on pvs_pkg.
`default_nettype none
module pvs_gain (
  input  logic                       clk,
  input  logic                       en,
  input  pvs_pkg::vec_t              d,
  output logic [pvs_pkg::OLW-1:0]    sum_length,
  output logic signed [pvs_pkg::OAW-1:0] sum_angle
);
  import pvs_pkg::*;

  logic [VW-2:0] xc;
  logic [17:0] x_lo;
  logic [VW-20:0] x_hi;
  logic [46:0] p_lo;
  logic [VW+9:0] p_hi;
  logic signed [ZW-1:0] zr;
  logic signed [ZW-14:0] a_full;
  logic signed [OAW-1:0] a_clamp;
  logic signed [OAW-1:0] ang;
  logic zero;
  logic [65:0] tot;
  logic [21:0] len_full;
  logic [OLW-1:0] len_sat;

  always_comb begin
    xc = d.x[VW-1] ? '0 : d.x[VW-2:0];
    x_lo = xc[17:0];
    x_hi = xc[VW-2:18];
    zr = d.z + 32'sd4096;
    a_full = zr[ZW-1:13];
    if (a_full > HALF_TURN) begin
      a_clamp = OAW'(HALF_TURN);
    end else if (a_full < -HALF_TURN) begin
      a_clamp = -OAW'(HALF_TURN);
    end else begin
      a_clamp = a_full[OAW-1:0];
    end
    tot = (66'(p_hi) << 18) + 66'(p_lo) + (66'd1 << 43);
    len_full = tot[65:44];
    len_sat = (len_full > 22'h1FFFF) ? {OLW{1'b1}} : len_full[OLW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo <= 47'(x_lo) * 47'(GAIN_SQ_INV);
      p_hi <= (VW+10)'(x_hi) * (VW+10)'(GAIN_SQ_INV);
      ang <= d.zero ? '0 : a_clamp;
      zero <= d.zero;
      sum_length <= zero ? '0 : len_sat;
      sum_angle <= ang;
    end
  end
endmodule
`default_nettype wire

>>> rtl/pvs_checker.sv
// Port-level checks for polar_vector_sum, bound to the top level.
// Depends on assert_macros.svh and pvs_pkg.
`default_nettype none
`include "assert_macros.svh"
module pvs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_stall,
  input logic                           rsp_valid,
  input logic                           rsp_stall,
  input logic signed [pvs_pkg::OAW-1:0] sum_angle
);
  `PVS_IMPLY(a_hold, rsp_valid && rsp_stall, ##1 rsp_valid)
  `PVS_IMPLY(a_range, rsp_valid, (sum_angle >= -16'sd23040) && (sum_angle <= 16'sd23040))
  `PVS_IMPLY(a_stall_src, req_stall, rsp_valid && rsp_stall)
  `PVS_IMPLY(a_drain, rsp_valid && !rsp_stall && !req_valid, !req_stall)
endmodule

bind polar_vector_sum pvs_checker u_pvs_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .sum_angle(sum_angle)
);
`default_nettype wire

>>> dv/polar_vector_sum_checker.sv
// Checker for polar_vector_sum: watches both channels, predicts each result
// with a bit-accurate CORDIC model and compares. Depends on pvs_pkg.
module polar_vector_sum_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic                           req_stall,
  input  logic [pvs_pkg::LW-1:0]         first_length,
  input  logic signed [pvs_pkg::AW-1:0]  first_angle,
  input  logic [pvs_pkg::LW-1:0]         second_length,
  input  logic signed [pvs_pkg::AW-1:0]  second_angle,
  input  logic                           rsp_valid,
  input  logic                           rsp_stall,
  input  logic [pvs_pkg::OLW-1:0]        sum_length,
  input  logic signed [pvs_pkg::OAW-1:0] sum_angle,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pvs_pkg::*;

  typedef struct packed {
    logic [OLW-1:0]        len;
    logic signed [OAW-1:0] ang;
  } polar_t;

  polar_t sums_q[$];

  function automatic longint atan_deg(input int i);
    return longint'(atan_tab(i));
  endfunction

  task automatic to_xy(input logic [LW-1:0] len, input logic signed [AW-1:0] ang,
                       output longint ox, output longint oy);
    longint a, x, y, z, dx, dy;
    bit flip;
    a = ang;
    flip = 0;
    while (a >= HALF_TURN) a -= FULL_TURN;
    while (a < -HALF_TURN) a += FULL_TURN;
    if (a > QUARTER_TURN) begin
      a -= HALF_TURN;
      flip = 1;
    end else if (a < -QUARTER_TURN) begin
      a += HALF_TURN;
      flip = 1;
    end
    x = longint'(len) <<< 14;
    y = 0;
    z = a * 8192;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_deg(i);
      end else begin
        x += dx; y -= dy; z += atan_deg(i);
      end
    end
    ox = flip ? -x : x;
    oy = flip ? -y : y;
  endtask

  task automatic predict_sum(output polar_t r);
    longint x1, y1, x2, y2, x, y, z, base, dx, dy, ang;
    logic [127:0] prod;
    to_xy(first_length, first_angle, x1, y1);
    to_xy(second_length, second_angle, x2, y2);
    x = x1 + x2;
    y = y1 + y2;
    base = 0;
    if (x == 0 && y == 0) begin
      r = '0;
      return;
    end
    if (x < 0) begin
      base = (y >= 0) ? 188743680 : -188743680;
      x = -x;
      y = -y;
    end
    z = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= atan_deg(i);
      end else begin
        x += dx; y -= dy; z += atan_deg(i);
      end
    end
    z += base;
    if (x < 0) x = 0;
    prod = (128'(x) * 128'(GAIN_SQ_INV) + (128'd1 << 43)) >> 44;
    if (prod > 128'h1FFFF) prod = 128'h1FFFF;
    ang = (z + 4096) >>> 13;
    if (ang > HALF_TURN) ang = HALF_TURN;
    if (ang < -HALF_TURN) ang = -HALF_TURN;
    r.len = prod[OLW-1:0];
    r.ang = ang[OAW-1:0];
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial errors = 0;
  assign pending = sums_q.size();

  always @(posedge clk) begin
    polar_t p, e;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        predict_sum(p);
        sums_q.push_back(p);
      end
      if (rsp_valid && !rsp_stall) begin
        if (sums_q.size() == 0) begin
          report("unexpected transfer", sum_length, 0);
        end else begin
          e = sums_q.pop_front();
          if (sum_length !== e.len) report("sum_length", sum_length, e.len);
          if (sum_angle !== e.ang) report("sum_angle", sum_angle, e.ang);
        end
      end
    end
  end
endmodule

>>> dv/polar_vector_sum_tb.sv
// Top of the polar_vector_sum testbench: clock, reset, stimulus and verdict.
// Depends on pvs_pkg, polar_vector_sum and polar_vector_sum_checker.
module polar_vector_sum_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pvs_pkg::*;

  localparam int STEPS = 16;
  localparam int LATENCY = 2 * STEPS + 4;
  localparam int LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [LW-1:0] first_length = '0;
  logic signed [AW-1:0] first_angle = '0;
  logic [LW-1:0] second_length = '0;
  logic signed [AW-1:0] second_angle = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [OLW-1:0] sum_length;
  logic signed [OAW-1:0] sum_angle;
  int errors, pending;
  int cycles = 0;
  int stall_mode = 0;

  always #5 clk = ~clk;

  polar_vector_sum #(.CORDIC_STEPS(STEPS)) i_dut (.*);
  polar_vector_sum_checker #(.CORDIC_STEPS(STEPS)) i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("polar_vector_sum_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 1) == 0);
      default: rsp_stall <= (cycles % 7) < 4;
    endcase
  end

  function automatic logic signed [AW-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return AW'($urandom_range(0, 8) * 5760 - FULL_TURN);
      1: return AW'(int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
      2: return AW'(int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN);
      default: return AW'($urandom());
    endcase
  endfunction

  task automatic send(input logic [LW-1:0] l1, input logic signed [AW-1:0] a1,
                      input logic [LW-1:0] l2, input logic signed [AW-1:0] a2);
    req_valid <= 1'b1;
    first_length <= l1;
    first_angle <= a1;
    second_length <= l2;
    second_angle <= a2;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    logic [LW-1:0] l;
    int burst;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(16'h0000, '0, 16'h0000, '0);
    send(16'hFFFF, '0, 16'hFFFF, '0);
    send(16'hFFFF, '0, 16'hFFFF, AW'(HALF_TURN));
    send(16'hFFFF, AW'(-HALF_TURN), 16'hFFFF, AW'(-HALF_TURN));
    send(16'h0100, AW'(FULL_TURN), 16'h0100, AW'(-FULL_TURN));
    send(16'h0100, AW'(QUARTER_TURN), 16'h0100, AW'(-QUARTER_TURN));
    send(16'h0100, AW'(QUARTER_TURN + 1), 16'h0000, '0);
    send(16'h0100, AW'(-QUARTER_TURN - 1), 16'h0000, '0);
    send(16'h1234, AW'(HALF_TURN - 1), 16'h0000, '0);
    send(16'h1234, AW'(-HALF_TURN + 1), 16'h0000, '0);
    send(16'h8000, AW'(17280), 16'h8000, AW'(-17280));
    send(16'h0001, '0, 16'h0000, '0);
    send(16'hFFFF, AW'(65535), 16'hFFFF, AW'(-65536));
    send(16'hAAAA, AW'(-1), 16'h5555, AW'(1));
    send(16'h0200, AW'(5760), 16'h0200, AW'(-17280));
    for (int n = 0; n < 850; n += burst) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) begin
        l = ($urandom_range(0, 3) == 0) ? LW'($urandom_range(0, 3)) : LW'($urandom());
        send(l, rand_angle(), LW'($urandom()), rand_angle());
      end
      pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
    end
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("polar_vector_sum_tb OK");
    end else begin
      $display("polar_vector_sum_tb NOT OK");
    end
    $finish;
  end
endmodule
